[rtl/circle_rasterizer_defines.svh]
// Assertion helpers for the RTL file that checks its own logic.
`ifndef CIRCLE_RASTERIZER_DEFINES_SVH
`define CIRCLE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CRAST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define CRAST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/crast_pkg.sv]
package crast_pkg;

  localparam int COORD_BITS = 10;
  localparam int STEP_W     = COORD_BITS + 1;
  localparam int DEC_W      = COORD_BITS + 6;
  localparam int PIX_W      = 12;
  localparam int SUM_W      = (COORD_BITS + 3 > PIX_W) ? COORD_BITS + 3 : PIX_W + 1;
  localparam int DIM_W      = 11;
  localparam int IDX_W      = 3;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(400);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(400);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(7);

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
  } in_item_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    pixel_valid;
    logic                    inside_image;
    logic                    last;
    logic                    circle_done;
  } out_item_t;

  // One step's worth of work handed to the pixel emitter.
  typedef struct packed {
    logic                    pix;
    logic                    done;
    logic [STEP_W-1:0]       x;
    logic signed [STEP_W-1:0] y;
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;
  } job_t;

endpackage

[rtl/circle_rasterizer.sv]
// Circle rasterizer, midpoint decision variable with eight-way mirroring.
// A step item with a point left yields eight results, one per cycle while
// out_ready holds; a step with nothing left to draw yields one done result.
// The next item is taken as the emitter loads the last result of a step.
// Reset (synchronous, rst_n low): no circle active, image size 400 x 400.
`include "circle_rasterizer_defines.svh"

module circle_rasterizer
  import crast_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [DIM_W-1:0]         width_r;
  logic [DIM_W-1:0]         height_r;
  logic [COORD_BITS-1:0]    cx_r;
  logic [COORD_BITS-1:0]    cy_r;
  logic [STEP_W-1:0]        x_r;
  logic signed [STEP_W-1:0] y_r;
  logic signed [DEC_W-1:0]  d_r;
  logic                     run_r;

  logic [STEP_W-1:0]        x_nxt;
  logic signed [STEP_W-1:0] y_nxt;
  logic signed [DEC_W-1:0]  d_nxt;

  logic                     in_fire;
  logic                     cfg_wr;
  logic                     job_ready;
  logic                     job_valid;
  job_t                     job;

  logic signed [STEP_W:0]   xs;
  logic signed [STEP_W:0]   ys;
  logic signed [STEP_W:0]   xs_nxt;
  logic signed [STEP_W:0]   ys_nxt;
  logic signed [STEP_W:0]   diff;
  logic                     have_point;
  logic                     dec_le0;
  logic                     done_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_WIDTH:  cfg_prdata = DATA_W'(width_r);
      REG_HEIGHT: cfg_prdata = DATA_W'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) begin
        width_r <= cfg_pwdata[DIM_W-1:0];
      end else begin
        height_r <= cfg_pwdata[DIM_W-1:0];
      end
    end
  end

  assign in_ready = job_ready;
  assign in_fire  = in_valid && in_ready;

  assign xs         = $signed({1'b0, x_r});
  assign ys         = {y_r[STEP_W-1], y_r};
  assign have_point = run_r && !(xs > ys);
  assign dec_le0    = d_r[DEC_W-1] || (d_r == '0);
  assign diff       = xs - ys;

  // Advance the octant point; y drops only when the decision is positive.
  always_comb begin
    x_nxt = x_r + STEP_W'(1);
    if (dec_le0) begin
      y_nxt = y_r;
      d_nxt = d_r + $signed({{(DEC_W-STEP_W-2){1'b0}}, x_r, 2'b00}) + DEC_W'(6);
    end else begin
      y_nxt = y_r - STEP_W'(1);
      d_nxt = d_r + $signed({{(DEC_W-STEP_W-3){diff[STEP_W]}}, diff, 2'b00}) + DEC_W'(10);
    end
  end

  assign xs_nxt   = $signed({1'b0, x_nxt});
  assign ys_nxt   = {y_nxt[STEP_W-1], y_nxt};
  assign done_nxt = xs_nxt > ys_nxt;

  assign job_valid = in_fire && (in_data.action == ACT_STEP);
  assign job.pix   = have_point;
  assign job.done  = done_nxt;
  assign job.x     = x_r;
  assign job.y     = y_r;
  assign job.cx    = cx_r;
  assign job.cy    = cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      x_r   <= '0;
      y_r   <= '0;
      d_r   <= '0;
      cx_r  <= '0;
      cy_r  <= '0;
    end else if (in_fire) begin
      if (in_data.action == ACT_START) begin
        cx_r  <= in_data.center_x;
        cy_r  <= in_data.center_y;
        x_r   <= '0;
        y_r   <= $signed({1'b0, in_data.radius});
        d_r   <= DEC_W'(3) - $signed({{(DEC_W-COORD_BITS-1){1'b0}}, in_data.radius, 1'b0});
        run_r <= 1'b1;
      end else if (have_point) begin
        x_r   <= x_nxt;
        y_r   <= y_nxt;
        d_r   <= d_nxt;
        run_r <= !done_nxt;
      end else begin
        run_r <= 1'b0;
      end
    end
  end

  crast_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (job_valid),
    .job          (job),
    .job_ready    (job_ready),
    .image_width  (width_r),
    .image_height (height_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  `CRAST_ASSERT_NEXT(a_start_runs, in_fire && (in_data.action == ACT_START), run_r, "start did not arm the circle")
  `CRAST_ASSERT_NOW(a_run_point_left, run_r, !(xs > ys), "circle active with no octant point left")
  `CRAST_ASSERT_NOW(a_done_only_shape, out_valid && !out_data.pixel_valid, out_data.last && out_data.circle_done && !out_data.inside_image, "malformed done result")

endmodule

[rtl/crast_emit.sv]
module crast_emit
  import crast_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  job_t             job,
  output logic             job_ready,
  input  logic [DIM_W-1:0] image_width,
  input  logic [DIM_W-1:0] image_height,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  logic             busy_r;
  job_t             job_r;
  logic [IDX_W-1:0] idx_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic load;
  logic last_now;

  logic signed [SUM_W-1:0] xo;
  logic signed [SUM_W-1:0] yo;
  logic signed [SUM_W-1:0] ox;
  logic signed [SUM_W-1:0] oy;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] w_s;
  logic signed [SUM_W-1:0] h_s;
  logic                    in_image;
  out_item_t               res;

  assign load      = busy_r && (!out_valid_r || out_ready);
  assign last_now  = !job_r.pix || (idx_r == LAST_IDX);
  assign job_ready = !busy_r || (load && last_now);

  assign xo = $signed({{(SUM_W-STEP_W){1'b0}}, job_r.x});
  assign yo = SUM_W'(job_r.y);

  // Octant mirror order: (x,y) (-x,y) (x,-y) (-x,-y) (y,x) (y,-x) (-y,x) (-y,-x)
  always_comb begin
    case (idx_r)
      3'd0:    begin ox =  xo; oy =  yo; end
      3'd1:    begin ox = -xo; oy =  yo; end
      3'd2:    begin ox =  xo; oy = -yo; end
      3'd3:    begin ox = -xo; oy = -yo; end
      3'd4:    begin ox =  yo; oy =  xo; end
      3'd5:    begin ox =  yo; oy = -xo; end
      3'd6:    begin ox = -yo; oy =  xo; end
      default: begin ox = -yo; oy = -xo; end
    endcase
  end

  assign sum_x = $signed({{(SUM_W-COORD_BITS){1'b0}}, job_r.cx}) + ox;
  assign sum_y = $signed({{(SUM_W-COORD_BITS){1'b0}}, job_r.cy}) + oy;
  assign w_s   = $signed({{(SUM_W-DIM_W){1'b0}}, image_width});
  assign h_s   = $signed({{(SUM_W-DIM_W){1'b0}}, image_height});
  assign in_image = !sum_x[SUM_W-1] && !sum_y[SUM_W-1] && (sum_x < w_s) && (sum_y < h_s);

  always_comb begin
    if (job_r.pix) begin
      res.pixel_x      = sum_x[PIX_W-1:0];
      res.pixel_y      = sum_y[PIX_W-1:0];
      res.pixel_valid  = 1'b1;
      res.inside_image = in_image;
      res.last         = (idx_r == LAST_IDX);
      res.circle_done  = job_r.done;
    end else begin
      res.pixel_x      = '0;
      res.pixel_y      = '0;
      res.pixel_valid  = 1'b0;
      res.inside_image = 1'b0;
      res.last         = 1'b1;
      res.circle_done  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (job_valid && job_ready) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (load && last_now) begin
        busy_r <= 1'b0;
      end else if (load) begin
        idx_r <= idx_r + IDX_W'(1);
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      job_r <= job;
    end
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
